FILE: rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg: shared types, constants and helpers for the battery gauge
// Discharge curve, register indexes, pipeline payload types and the
// compare/subtract step used by the percentage divider.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

   // discharge curve: first threshold not below the sample gives index*5 %
   localparam int unsigned CurvePoints = 21;
   localparam logic [15:0] CURVE_MV [CurvePoints] = '{
      16'd3399, 16'd3620, 16'd3670, 16'd3710, 16'd3730, 16'd3740, 16'd3750,
      16'd3780, 16'd3795, 16'd3815, 16'd3825, 16'd3880, 16'd3925, 16'd3980,
      16'd4045, 16'd4070, 16'd4135, 16'd4200, 16'd4225, 16'd4285, 16'hFFFF
   };

   localparam int unsigned IdxW   = 5;    // curve index 0..20
   localparam int unsigned PctW   = 7;    // percentages 0..127
   localparam int unsigned NumW   = 11;   // index*100 up to 2000
   localparam int unsigned QuoW   = 7;    // quotient below 128
   localparam int unsigned QuoSplit = 4;  // quotient bits done in the output stage

   localparam logic [PctW-1:0] PCT_STEP = 7'd5;
   localparam logic [PctW-1:0] PCT_FULL = 7'd100;
   localparam logic [NumW-1:0] NUM_SCALE = 11'd100;

   // status / control byte fields
   localparam int unsigned CHG_ENABLE_BIT = 4;
   localparam int unsigned PWR_GOOD_BIT   = 2;
   localparam logic [1:0]  CHG_STATE_DONE = 2'b11;

   typedef logic [IdxW-1:0] idx_type;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_FULL_MV      = 2'd0,
      CSR_STOP_PCT     = 2'd1,
      CSR_RESUME_PCT   = 2'd2,
      CSR_STORAGE_MODE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0]     full_voltage_mv;
      logic [PctW-1:0] stop_percent;
      logic [PctW-1:0] resume_percent;
      logic            storage_mode;
   } cfg_type;

   // curve stage -> band stage
   typedef struct packed {
      idx_type    raw_idx;
      idx_type    full_idx;
      logic       mv_nonzero;
      logic [7:0] status_byte;
      logic [7:0] control_byte;
   } curve_type;

   // band stage -> output stage
   typedef struct packed {
      idx_type         raw_idx;
      idx_type         full_idx;
      logic [PctW-1:0] raw_pct;
      logic [NumW-1:0] rem;
      logic [QuoW-1:0] quo;
      logic            write_needed;
      logic [7:0]      new_control_byte;
   } band_type;

   typedef struct packed {
      logic [PctW-1:0] charge_percent;
      logic            write_needed;
      logic [7:0]      new_control_byte;
   } result_type;

   // priority search over the curve thresholds
   function automatic idx_type curve_index(input logic [15:0] mv);
      idx_type idx;
      idx = IdxW'(CurvePoints - 1);
      for (int i = CurvePoints - 1; i >= 0; i--) begin
         if (mv <= CURVE_MV[i]) begin
            idx = IdxW'(i);
         end
      end
      return idx;
   endfunction

   // one restoring-division step: {quotient bit, new remainder}
   function automatic logic [NumW:0] div_step(input logic [NumW-1:0] rem,
                                              input logic [NumW-1:0] dsh);
      if (rem >= dsh) begin
         return {1'b1, rem - dsh};
      end
      return {1'b0, rem};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bgc_if.sv
// ----------------------------------------------------------------------------
// bgc_if: valid/ready channels of the battery gauge
// Request channel carries a sample with the charger bytes, response channel
// carries the gauge result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] battery_mv;
   logic [7:0]  status_byte;
   logic [7:0]  control_byte;

   modport source (output valid, output battery_mv, output status_byte,
                   output control_byte, input ready);
   modport sink   (input valid, input battery_mv, input status_byte,
                   input control_byte, output ready);
endinterface

interface bgc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] charge_percent;
   logic       write_needed;
   logic [7:0] new_control_byte;

   modport source (output valid, output charge_percent, output write_needed,
                   output new_control_byte, input ready);
   modport sink   (input valid, input charge_percent, input write_needed,
                   input new_control_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/bgc_curve_stage.sv
// ----------------------------------------------------------------------------
// bgc_curve_stage: first pipeline stage
// Maps the sample and the full-charge voltage to curve indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_curve_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bgc_pkg::cfg_type   cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [15:0]        battery_mv,
   input  wire logic [7:0]         status_byte,
   input  wire logic [7:0]         control_byte,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output bgc_pkg::curve_type      out_data
);

   logic               valid_ff;
   bgc_pkg::curve_type data_ff;
   bgc_pkg::curve_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // curve searches for sample and full voltage
   always_comb begin
      data_in.raw_idx      = bgc_pkg::curve_index(battery_mv);
      data_in.full_idx     = bgc_pkg::curve_index(cfg.full_voltage_mv);
      data_in.mv_nonzero   = (battery_mv != 16'd0);
      data_in.status_byte  = status_byte;
      data_in.control_byte = control_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/bgc_band_stage.sv
// ----------------------------------------------------------------------------
// bgc_band_stage: second pipeline stage
// Charge band control on the unscaled curve percentage, and the upper
// quotient bits of the percentage scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_band_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bgc_pkg::cfg_type   cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire bgc_pkg::curve_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output bgc_pkg::band_type       out_data
);

   logic                       valid_ff;
   bgc_pkg::band_type          data_ff;
   bgc_pkg::band_type          data_in;
   logic [bgc_pkg::NumW:0]     step;
   logic [bgc_pkg::NumW-1:0]   rem;
   logic [7:0]                 ctrl;
   logic                       band_on;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.raw_idx  = in_data.raw_idx;
      data_in.full_idx = in_data.full_idx;
      data_in.raw_pct  = bgc_pkg::PctW'(in_data.raw_idx) * bgc_pkg::PCT_STEP;

      // upper quotient bits of raw_idx*100 / full_idx
      rem = bgc_pkg::NumW'(in_data.raw_idx) * bgc_pkg::NUM_SCALE;
      data_in.quo = '0;
      for (int k = bgc_pkg::QuoW - 1; k >= bgc_pkg::QuoSplit; k--) begin
         step = bgc_pkg::div_step(rem, bgc_pkg::NumW'(in_data.full_idx) << k);
         data_in.quo[k] = step[bgc_pkg::NumW];
         rem = step[bgc_pkg::NumW-1:0];
      end
      data_in.rem = rem;

      // hysteresis band on the charge enable bit
      ctrl    = in_data.control_byte;
      band_on = in_data.mv_nonzero && cfg.storage_mode &&
                in_data.status_byte[bgc_pkg::PWR_GOOD_BIT];
      if (band_on) begin
         if (ctrl[bgc_pkg::CHG_ENABLE_BIT]) begin
            if (in_data.status_byte[4:3] == bgc_pkg::CHG_STATE_DONE ||
                data_in.raw_pct >= cfg.stop_percent) begin
               ctrl[bgc_pkg::CHG_ENABLE_BIT] = 1'b0;
            end
         end else if (data_in.raw_pct <= cfg.resume_percent) begin
            ctrl[bgc_pkg::CHG_ENABLE_BIT] = 1'b1;
         end
      end
      data_in.new_control_byte = ctrl;
      data_in.write_needed     = (ctrl != in_data.control_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/bgc_out_stage.sv
// ----------------------------------------------------------------------------
// bgc_out_stage: last pipeline stage and result register
// Finishes the quotient, applies the cap and the zero-scale case.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bgc_pkg::band_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output bgc_pkg::result_type    out_data
);

   logic                       valid_ff;
   bgc_pkg::result_type        data_ff;
   bgc_pkg::result_type        data_in;
   logic [bgc_pkg::NumW:0]     step;
   logic [bgc_pkg::NumW-1:0]   rem;
   logic [bgc_pkg::QuoW-1:0]   quo;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      // lower quotient bits
      rem = in_data.rem;
      quo = in_data.quo;
      for (int k = bgc_pkg::QuoSplit - 1; k >= 0; k--) begin
         step = bgc_pkg::div_step(rem, bgc_pkg::NumW'(in_data.full_idx) << k);
         quo[k] = step[bgc_pkg::NumW];
         rem = step[bgc_pkg::NumW-1:0];
      end

      // zero scale passes the curve value; at or above full caps at 100
      if (in_data.full_idx == '0) begin
         data_in.charge_percent = in_data.raw_pct;
      end else if (in_data.raw_idx >= in_data.full_idx) begin
         data_in.charge_percent = bgc_pkg::PCT_FULL;
      end else begin
         data_in.charge_percent = quo;
      end
      data_in.write_needed     = in_data.write_needed;
      data_in.new_control_byte = in_data.new_control_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/battery_gauge_charge_band_control.sv
// ----------------------------------------------------------------------------
// battery_gauge_charge_band_control: battery gauge with charge band control
// Curve lookup of the sample, percentage scaling against the full-charge
// voltage, and hysteresis control of the charger's enable bit.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------
//  req_ch   | in  | valid/ready    | battery_mv, status_byte, control_byte
//  rsp_ch   | out | valid/ready    | charge_percent, write_needed,
//           |     |                | new_control_byte
//  csr_*    | in  | csr_wr_en only | csr_index, csr_wr_data
//
//  One item per cycle while rsp_ch is not stalled; each item is registered
//  in the curve stage, the band stage and the output stage in turn, and its
//  result is offered on rsp_ch from the output stage register.
//  Reset clears the stage valid bits and loads the register defaults.
//  Each stage holds while the stage after it is full and stalled; an empty
//  stage keeps accepting, so bubbles are absorbed while rsp_ch is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_gauge_charge_band_control (
   input  wire logic  clock,
   input  wire logic  reset,
   bgc_req_if.sink    req_ch,
   bgc_rsp_if.source  rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wr_data
);

   bgc_pkg::cfg_type    cfg_ff;
   logic                s1_valid;
   logic                s1_ready;
   bgc_pkg::curve_type  s1_data;
   logic                s2_valid;
   logic                s2_ready;
   bgc_pkg::band_type   s2_data;
   bgc_pkg::result_type rsp_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_voltage_mv <= 16'd4096;
         cfg_ff.stop_percent    <= 7'd80;
         cfg_ff.resume_percent  <= 7'd75;
         cfg_ff.storage_mode    <= 1'b1;
      end else if (csr_wr_en) begin
         case (bgc_pkg::csr_index_type'(csr_index))
            bgc_pkg::CSR_FULL_MV: begin
               cfg_ff.full_voltage_mv <= csr_wr_data;
            end
            bgc_pkg::CSR_STOP_PCT: begin
               cfg_ff.stop_percent <= csr_wr_data[bgc_pkg::PctW-1:0];
            end
            bgc_pkg::CSR_RESUME_PCT: begin
               cfg_ff.resume_percent <= csr_wr_data[bgc_pkg::PctW-1:0];
            end
            bgc_pkg::CSR_STORAGE_MODE: begin
               cfg_ff.storage_mode <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   bgc_curve_stage u_curve (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .battery_mv   (req_ch.battery_mv),
      .status_byte  (req_ch.status_byte),
      .control_byte (req_ch.control_byte),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_data     (s1_data)
   );

   bgc_band_stage u_band (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   bgc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.charge_percent   = rsp_data.charge_percent;
   assign rsp_ch.write_needed     = rsp_data.write_needed;
   assign rsp_ch.new_control_byte = rsp_data.new_control_byte;

endmodule

`default_nettype wire

FILE: rtl/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_checker: port-level checks for the battery gauge
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] charge_percent,
   input wire logic       write_needed,
   input wire logic [7:0] new_control_byte
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(charge_percent) &&
      $stable(write_needed) && $stable(new_control_byte))
      else $error("rsp payload changed while stalled");

   // reported percentage never exceeds full scale
   a_pct_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> charge_percent <= 7'd100)
      else $error("charge_percent above 100");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind battery_gauge_charge_band_control bgc_checker u_bgc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .charge_percent   (rsp_ch.charge_percent),
   .write_needed     (rsp_ch.write_needed),
   .new_control_byte (rsp_ch.new_control_byte)
);

`default_nettype wire
